// ----- design/fmg_pkg.sv -----
// Package for the fuzzy membership grade unit: register indexes, the types that
// travel between the pipeline modules and the operand preparation function.
// Depends on nothing.
package fmg_pkg;

    localparam int DIFF_W = 65;

    localparam logic [2:0] REG_SHAPE_MODE = 3'd0;
    localparam logic [2:0] REG_POINT_A    = 3'd1;
    localparam logic [2:0] REG_POINT_B    = 3'd2;
    localparam logic [2:0] REG_POINT_C    = 3'd3;
    localparam logic [2:0] REG_POINT_D    = 3'd4;

    // One division request: magnitudes and the flags that settle the result early.
    typedef struct packed {
        logic              zero;
        logic              one;
        logic [DIFF_W-1:0] num;
        logic [DIFF_W-1:0] den;
    } lane_t;

    typedef struct packed {
        logic zero;
        logic one;
    } flags_t;

    typedef struct packed {
        logic trap;
        logic snap;
        logic outside;
        logic at_peak;
        logic below_peak;
    } side_t;

    // Signs and magnitudes of a quotient's operands. In trapezoid mode the
    // divisor carries one extra raw unit, folded into the magnitude here.
    function automatic lane_t lane_prep(logic signed [DIFF_W-1:0] n,
                                        logic signed [DIFF_W-1:0] d,
                                        logic trap);
        lane_t l;
        logic  n_neg;
        logic  d_neg;
        logic  d_zero;
        n_neg = n[DIFF_W-1];
        if (trap) begin
            d_neg  = d[DIFF_W-1] && (d != '1);
            d_zero = (d == '1);
            l.den  = d[DIFF_W-1] ? DIFF_W'(~d) : DIFF_W'(d + 1'b1);
        end else begin
            d_neg  = d[DIFF_W-1];
            d_zero = (d == '0);
            l.den  = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        end
        l.num  = n_neg ? DIFF_W'(-n) : DIFF_W'(n);
        l.zero = d_zero || (n == '0) || (n_neg != d_neg);
        l.one  = 1'b0;
        return l;
    endfunction

endpackage

// ----- design/fmg_prep.sv -----
// Front end of the grade pipeline: set point differences, operand magnitudes
// and the early-out compares, over three register stages. Uses fmg_pkg.
module fmg_prep (
    input  logic                aclk,
    input  logic                adv,
    input  logic [63:0]         sample,
    input  logic                snap,
    input  logic                trap,
    input  logic [63:0]         pa,
    input  logic [63:0]         pb,
    input  logic [63:0]         pc,
    input  logic [63:0]         pd,
    output fmg_pkg::lane_t      rise_lane,
    output fmg_pkg::lane_t      fall_lane,
    output fmg_pkg::side_t      side
);
    logic signed [64:0] n1_reg, d1_reg, n2_reg, d2_reg;
    logic signed [64:0] sx, sa, sb, sc, sd;
    fmg_pkg::side_t     side1_reg, side2_reg, side3_reg;
    fmg_pkg::side_t     side1_next;
    fmg_pkg::lane_t     rise2_reg, fall2_reg, rise3_reg, fall3_reg;

    assign sx = {sample[63], sample};
    assign sa = {pa[63], pa};
    assign sb = {pb[63], pb};
    assign sc = {pc[63], pc};
    assign sd = {pd[63], pd};

    always_comb begin
        side1_next.trap       = trap;
        side1_next.snap       = snap;
        side1_next.outside    = !($signed(pa) < $signed(sample))
                                || !($signed(sample) < $signed(pc));
        side1_next.at_peak    = (sample == pb);
        side1_next.below_peak = $signed(sample) < $signed(pb);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n1_reg    <= sx - sa;
            d1_reg    <= sb - sa;
            n2_reg    <= (trap ? sd : sc) - sx;
            d2_reg    <= trap ? (sd - sc) : (sc - sb);
            side1_reg <= side1_next;

            rise2_reg <= fmg_pkg::lane_prep(n1_reg, d1_reg, side1_reg.trap);
            fall2_reg <= fmg_pkg::lane_prep(n2_reg, d2_reg, side1_reg.trap);
            side2_reg <= side1_reg;

            rise3_reg <= '{zero: rise2_reg.zero, one: rise2_reg.num >= rise2_reg.den,
                           num: rise2_reg.num, den: rise2_reg.den};
            fall3_reg <= '{zero: fall2_reg.zero, one: fall2_reg.num >= fall2_reg.den,
                           num: fall2_reg.num, den: fall2_reg.den};
            side3_reg <= side2_reg;
        end
    end

    assign rise_lane = rise3_reg;
    assign fall_lane = fall3_reg;
    assign side      = side3_reg;
endmodule

// ----- design/fmg_div_lane.sv -----
// Pipelined restoring divider: one quotient bit per register stage, giving the
// fractional quotient of a proper fraction. Uses fmg_pkg.
module fmg_div_lane #(
    parameter int FRAC_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 adv,
    input  fmg_pkg::lane_t       lane,
    output logic [FRAC_BITS-1:0] quo,
    output fmg_pkg::flags_t      flags
);
    logic [64:0]          rem_reg [FRAC_BITS];
    logic [64:0]          den_reg [FRAC_BITS];
    logic [FRAC_BITS-1:0] quo_reg [FRAC_BITS];
    fmg_pkg::flags_t      flg_reg [FRAC_BITS];

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
        logic [64:0]          rem_in, den_in;
        logic [FRAC_BITS-1:0] quo_in;
        fmg_pkg::flags_t      flg_in;
        logic [65:0]          trial;
        logic                 fits;

        if (k == 0) begin : g_first
            assign rem_in = lane.num;
            assign den_in = lane.den;
            assign quo_in = '0;
            assign flg_in = '{zero: lane.zero, one: lane.one};
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign flg_in = flg_reg[k-1];
        end

        // The remainder stays below the divisor, so the doubled value fits.
        assign trial = {rem_in, 1'b0};
        assign fits  = trial >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k] <= fits ? 65'(trial - {1'b0, den_in}) : trial[64:0];
                den_reg[k] <= den_in;
                quo_reg[k] <= {quo_in[FRAC_BITS-2:0], fits};
                flg_reg[k] <= flg_in;
            end
        end
    end

    assign quo   = quo_reg[FRAC_BITS-1];
    assign flags = flg_reg[FRAC_BITS-1];
endmodule

// ----- design/fuzzy_membership_grade_unit.sv -----
// Fuzzy membership grade unit: triangular or trapezoidal grade of a Q32.32 sample.
// A request passes the prep, divider and output registers; throughput is one
// request per cycle unless a result stalls, set by the one-bit-per-stage dividers.
// A stalled result holds the whole pipeline. aresetn is synchronous, active low:
// it empties the pipeline and sets trapezoid mode with points 0, 5, 10 and 15.
module fuzzy_membership_grade_unit #(
    parameter int FRAC_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [63:0]          s_sample_value,
    input  logic                 s_snap_enable,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FRAC_BITS:0]   m_grade,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_wr_index,
    input  logic [63:0]          cfg_wr_data
);
    localparam int PREP_STAGES = 3;
    localparam int BODY_STAGES = PREP_STAGES + FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic        shape_mode_reg;
    logic [63:0] point_a_reg, point_b_reg, point_c_reg, point_d_reg;

    logic                 adv;
    logic                 vld_reg [BODY_STAGES];
    logic                 m_valid_reg;
    logic [FRAC_BITS:0]   m_grade_reg;
    fmg_pkg::lane_t       rise_lane, fall_lane;
    fmg_pkg::side_t       side_prep;
    fmg_pkg::side_t       side_reg [FRAC_BITS];
    logic [FRAC_BITS-1:0] rise_q, fall_q;
    fmg_pkg::flags_t      rise_f, fall_f;
    logic [FRAC_BITS:0]   rise_g, fall_g, raw_g, grade_next;
    fmg_pkg::side_t       side_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_mode_reg <= 1'b1;
            point_a_reg    <= 64'd0;
            point_b_reg    <= 64'd5 << FRAC_BITS;
            point_c_reg    <= 64'd10 << FRAC_BITS;
            point_d_reg    <= 64'd15 << FRAC_BITS;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                fmg_pkg::REG_SHAPE_MODE: shape_mode_reg <= cfg_wr_data[0];
                fmg_pkg::REG_POINT_A:    point_a_reg    <= cfg_wr_data;
                fmg_pkg::REG_POINT_B:    point_b_reg    <= cfg_wr_data;
                fmg_pkg::REG_POINT_C:    point_c_reg    <= cfg_wr_data;
                fmg_pkg::REG_POINT_D:    point_d_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together whenever the output register can take a result.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    fmg_prep u_prep (
        .aclk      (aclk),
        .adv       (adv),
        .sample    (s_sample_value),
        .snap      (s_snap_enable),
        .trap      (shape_mode_reg),
        .pa        (point_a_reg),
        .pb        (point_b_reg),
        .pc        (point_c_reg),
        .pd        (point_d_reg),
        .rise_lane (rise_lane),
        .fall_lane (fall_lane),
        .side      (side_prep)
    );

    fmg_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_rise (
        .aclk  (aclk),
        .adv   (adv),
        .lane  (rise_lane),
        .quo   (rise_q),
        .flags (rise_f)
    );

    fmg_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_fall (
        .aclk  (aclk),
        .adv   (adv),
        .lane  (fall_lane),
        .quo   (fall_q),
        .flags (fall_f)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BODY_STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < BODY_STAGES; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_valid_reg <= vld_reg[BODY_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_prep;
            for (int i = 1; i < FRAC_BITS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            m_grade_reg <= grade_next;
        end
    end

    assign side_out = side_reg[FRAC_BITS-1];

    always_comb begin
        rise_g = rise_f.zero ? '0 : (rise_f.one ? ONE : {1'b0, rise_q});
        fall_g = fall_f.zero ? '0 : (fall_f.one ? ONE : {1'b0, fall_q});
        if (side_out.trap) begin
            raw_g = (rise_g < fall_g) ? rise_g : fall_g;
        end else if (side_out.outside) begin
            raw_g = '0;
        end else if (side_out.at_peak) begin
            raw_g = ONE;
        end else if (side_out.below_peak) begin
            raw_g = rise_g;
        end else begin
            raw_g = fall_g;
        end
        // At least one half means either of the top two bits is set.
        if (side_out.snap) begin
            grade_next = (raw_g[FRAC_BITS] || raw_g[FRAC_BITS-1]) ? ONE : '0;
        end else begin
            grade_next = raw_g;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_grade = m_grade_reg;

`ifndef SYNTH
    a_reset_empty : assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");
    a_grade_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_grade <= ONE))
        else $error("grade above one");
    a_snap_binary : assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && vld_reg[BODY_STAGES-1] && side_out.snap)
        |=> (m_grade == ONE || m_grade == '0))
        else $error("snapped grade is neither zero nor one");
`endif
endmodule
